### src/bpc_pkg.sv
// Shared types, constants and the divider step for the pressure compensation pipeline.
// No dependencies.
package bpc_pkg;

   typedef enum logic [7:0] {
      CSR_CAL_AC1_TO_AC4 = 8'd0,
      CSR_CAL_AC5_TO_B2  = 8'd1,
      CSR_CAL_MC_MD      = 8'd2,
      CSR_OVERSAMPLING   = 8'd3
   } csr_index_type;

   localparam logic [31:0] K_4000   = 32'd4000;
   localparam logic [31:0] K_32768  = 32'd32768;
   localparam logic [31:0] K_50000  = 32'd50000;
   localparam logic [31:0] K_3038   = 32'd3038;
   localparam logic [31:0] K_M7357  = 32'hFFFF_E343;
   localparam logic [31:0] K_3791   = 32'd3791;
   localparam int unsigned DIV_BITS = 32;

   // restoring divider state: one quotient bit per step
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] num;
      logic [31:0] quo;
      logic [31:0] den;
   } div_type;

   typedef struct packed {
      logic [18:0] up;
      logic [31:0] x1;
      logic        fault;
      logic        neg;
   } tmp_side_type;

   typedef struct packed {
      logic [31:0] b5;
      logic        big;
      logic        fault;
   } prs_side_type;

   function automatic div_type div_step(div_type d);
      div_type     r;
      logic [32:0] t;
      logic        ge;
      t     = {d.rem, d.num[31]};
      ge    = (t >= {1'b0, d.den});
      r.rem = ge ? 32'(t - {1'b0, d.den}) : t[31:0];
      r.num = {d.num[30:0], 1'b0};
      r.quo = {d.quo[30:0], ge};
      r.den = d.den;
      return r;
   endfunction

endpackage

### src/baro_pressure_compensation_top.sv
// Pressure compensation pipeline top level: config registers, datapath, output skid.
// Depends on bpc_pkg.
//
// Usage: req_ beats carry one raw temperature word and one raw pressure word.
// rsp_ beats return compensated pressure, the b5 temperature term and a
// divide fault flag (pressure is 0 when set). Calibration and oversampling
// are written through the csr_ port (always ready) while the block is idle.
// One beat per cycle is accepted sustained while the skid register is empty.
// Depth is set by two 32-stage bit-per-stage dividers (temperature term and
// pressure), twelve arithmetic stages and the output register.
// The whole pipeline advances together while the skid register is empty.
// When the receiver stalls, the next finished beat lands in the skid
// register and the pipeline then holds; nothing is dropped or repeated.
// Reset clears all valid bits and the configuration registers to zero.
module baro_pressure_compensation_top
   import bpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_raw_temperature,
   input  logic [18:0]        req_raw_pressure,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pressure_pa,
   output logic signed [31:0] rsp_temperature_term,
   output logic               rsp_divide_fault,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   localparam int unsigned NS = 2 * DIV_BITS + 12;

   // configuration
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_m_ff;
   logic [1:0]  oss_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_m_ff <= '0;
         oss_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAL_AC1_TO_AC4: cal_a_ff <= csr_wdata;
            CSR_CAL_AC5_TO_B2:  cal_b_ff <= csr_wdata;
            CSR_CAL_MC_MD:      cal_m_ff <= csr_wdata[31:0];
            CSR_OVERSAMPLING:   oss_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_a_ff[15]}}, cal_a_ff[15:0]};
   assign ac2 = {{16{cal_a_ff[31]}}, cal_a_ff[31:16]};
   assign ac3 = {{16{cal_a_ff[47]}}, cal_a_ff[47:32]};
   assign ac4 = {16'd0, cal_a_ff[63:48]};
   assign ac5 = {16'd0, cal_b_ff[15:0]};
   assign ac6 = {16'd0, cal_b_ff[31:16]};
   assign b1  = {{16{cal_b_ff[47]}}, cal_b_ff[47:32]};
   assign b2  = {{16{cal_b_ff[63]}}, cal_b_ff[63:48]};
   assign mc  = {{16{cal_m_ff[15]}}, cal_m_ff[15:0]};
   assign md  = {{16{cal_m_ff[31]}}, cal_m_ff[31:16]};

   // pipeline control
   logic          adv;
   logic [NS-1:0] vld_ff;
   logic          skid_v_ff, out_v_ff;
   logic          out_take;

   assign adv       = !skid_v_ff;
   assign req_ready = adv;
   assign out_take  = out_v_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   // stage 0: (ut - ac6) * ac5
   logic [31:0] s0_t_in, s0_t_ff;
   logic [18:0] s0_up_ff;
   assign s0_t_in = ({16'd0, req_raw_temperature} - ac6) * ac5;

   // stage 1: temperature divider setup
   logic [31:0]  s1_x1, s1_den, s1_num;
   div_type      s1_div_in, s1_div_ff;
   tmp_side_type s1_side_in, s1_side_ff;
   always_comb begin
      s1_x1            = $signed(s0_t_ff) >>> 15;
      s1_den           = s1_x1 + md;
      s1_num           = mc << 11;
      s1_div_in.rem    = '0;
      s1_div_in.quo    = '0;
      s1_div_in.num    = s1_num[31] ? 32'(-s1_num) : s1_num;
      s1_div_in.den    = s1_den[31] ? 32'(-s1_den) : s1_den;
      s1_side_in.up    = s0_up_ff;
      s1_side_in.x1    = s1_x1;
      s1_side_in.fault = (s1_den == '0);
      s1_side_in.neg   = s1_num[31] ^ s1_den[31];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_t_ff    <= s0_t_in;
         s0_up_ff   <= req_raw_pressure;
         s1_div_ff  <= s1_div_in;
         s1_side_ff <= s1_side_in;
      end
   end

   div_type      d1_ff   [DIV_BITS];
   tmp_side_type d1_sd_ff[DIV_BITS];

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div1
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (adv) begin
               d1_ff[k]    <= div_step(s1_div_ff);
               d1_sd_ff[k] <= s1_side_ff;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (adv) begin
               d1_ff[k]    <= div_step(d1_ff[k-1]);
               d1_sd_ff[k] <= d1_sd_ff[k-1];
            end
         end
      end
   end

   // stage 2: b5, b6
   tmp_side_type s2_sd;
   logic [31:0]  s2_q, s2_x2, s2_b5_in, s2_b6_in, s2_b5_ff, s2_b6_ff;
   logic [18:0]  s2_up_ff;
   logic         s2_fault_ff;
   always_comb begin
      s2_sd    = d1_sd_ff[DIV_BITS-1];
      s2_q     = d1_ff[DIV_BITS-1].quo;
      s2_x2    = s2_sd.fault ? '0 : (s2_sd.neg ? 32'(-s2_q) : s2_q);
      s2_b5_in = s2_sd.x1 + s2_x2;
      s2_b6_in = s2_b5_in - K_4000;
   end

   // stage 3: products of b6
   logic [31:0] s3_sq_in, s3_a2_in, s3_a3_in, s3_sq_ff, s3_a2_ff, s3_a3_ff, s3_b5_ff;
   logic [18:0] s3_up_ff;
   logic        s3_fault_ff;
   assign s3_sq_in = s2_b6_ff * s2_b6_ff;
   assign s3_a2_in = ac2 * s2_b6_ff;
   assign s3_a3_in = ac3 * s2_b6_ff;

   // stage 4: b2*sq, b1*sq
   logic [31:0] s4_sq, s4_b2_in, s4_b1_in, s4_x2_in, s4_x1_in;
   logic [31:0] s4_b2_ff, s4_b1_ff, s4_x2_ff, s4_x1_ff, s4_b5_ff;
   logic [18:0] s4_up_ff;
   logic        s4_fault_ff;
   always_comb begin
      s4_sq    = $signed(s3_sq_ff) >>> 12;
      s4_b2_in = b2 * s4_sq;
      s4_b1_in = b1 * s4_sq;
      s4_x2_in = $signed(s3_a2_ff) >>> 11;
      s4_x1_in = $signed(s3_a3_ff) >>> 13;
   end

   // stage 5: b3 and the b4 multiplicand
   logic [31:0] s5_x3, s5_sum, s5_t, s5_b3_in, s5_k_in, s5_b3_ff, s5_k_ff, s5_b5_ff;
   logic [18:0] s5_up_ff;
   logic        s5_fault_ff;
   always_comb begin
      s5_x3    = 32'($signed(s4_b2_ff) >>> 11) + s4_x2_ff;
      s5_t     = (((ac1 << 2) + s5_x3) << oss_ff) + 32'd2;
      s5_b3_in = $signed(s5_t) >>> 2;
      s5_sum   = s4_x1_ff + 32'($signed(s4_b1_ff) >>> 16) + 32'd2;
      s5_k_in  = 32'($signed(s5_sum) >>> 2) + K_32768;
   end

   // stage 6: b4, up - b3
   logic [31:0] s6_prod, s6_b4_in, s6_dd_in, s6_b4_ff, s6_dd_ff, s6_b5_ff;
   logic        s6_fault_ff;
   always_comb begin
      s6_prod  = ac4 * s5_k_ff;
      s6_b4_in = s6_prod >> 15;
      s6_dd_in = {13'd0, s5_up_ff} - s5_b3_ff;
   end

   // stage 7: b7
   logic [31:0] s7_b7_in, s7_b7_ff, s7_b4_ff, s7_b5_ff;
   logic        s7_fault_ff;
   assign s7_b7_in = s6_dd_ff * (K_50000 >> oss_ff);

   // stage 8: pressure divider setup
   div_type      s8_div_in, s8_div_ff;
   prs_side_type s8_side_in, s8_side_ff;
   always_comb begin
      s8_div_in.rem    = '0;
      s8_div_in.quo    = '0;
      s8_div_in.num    = s7_b7_ff[31] ? s7_b7_ff : {s7_b7_ff[30:0], 1'b0};
      s8_div_in.den    = s7_b4_ff;
      s8_side_in.b5    = s7_b5_ff;
      s8_side_in.big   = s7_b7_ff[31];
      s8_side_in.fault = s7_fault_ff || (s7_b4_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_b5_ff    <= s2_b5_in;
         s2_b6_ff    <= s2_b6_in;
         s2_up_ff    <= s2_sd.up;
         s2_fault_ff <= s2_sd.fault;
         s3_sq_ff    <= s3_sq_in;
         s3_a2_ff    <= s3_a2_in;
         s3_a3_ff    <= s3_a3_in;
         s3_b5_ff    <= s2_b5_ff;
         s3_up_ff    <= s2_up_ff;
         s3_fault_ff <= s2_fault_ff;
         s4_b2_ff    <= s4_b2_in;
         s4_b1_ff    <= s4_b1_in;
         s4_x2_ff    <= s4_x2_in;
         s4_x1_ff    <= s4_x1_in;
         s4_b5_ff    <= s3_b5_ff;
         s4_up_ff    <= s3_up_ff;
         s4_fault_ff <= s3_fault_ff;
         s5_b3_ff    <= s5_b3_in;
         s5_k_ff     <= s5_k_in;
         s5_b5_ff    <= s4_b5_ff;
         s5_up_ff    <= s4_up_ff;
         s5_fault_ff <= s4_fault_ff;
         s6_b4_ff    <= s6_b4_in;
         s6_dd_ff    <= s6_dd_in;
         s6_b5_ff    <= s5_b5_ff;
         s6_fault_ff <= s5_fault_ff;
         s7_b7_ff    <= s7_b7_in;
         s7_b4_ff    <= s6_b4_ff;
         s7_b5_ff    <= s6_b5_ff;
         s7_fault_ff <= s6_fault_ff;
         s8_div_ff   <= s8_div_in;
         s8_side_ff  <= s8_side_in;
      end
   end

   div_type      d2_ff   [DIV_BITS];
   prs_side_type d2_sd_ff[DIV_BITS];

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div2
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (adv) begin
               d2_ff[k]    <= div_step(s8_div_ff);
               d2_sd_ff[k] <= s8_side_ff;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (adv) begin
               d2_ff[k]    <= div_step(d2_ff[k-1]);
               d2_sd_ff[k] <= d2_sd_ff[k-1];
            end
         end
      end
   end

   // stage 9: raw p
   prs_side_type s9_sd, s9_sd_ff, s10_sd_ff, s11_sd_ff;
   logic [31:0]  s9_q, s9_p_in, s9_p_ff;
   always_comb begin
      s9_sd   = d2_sd_ff[DIV_BITS-1];
      s9_q    = d2_ff[DIV_BITS-1].quo;
      s9_p_in = s9_sd.big ? {s9_q[30:0], 1'b0} : s9_q;
   end

   // stage 10: correction products
   logic [31:0] s10_a, s10_aa_in, s10_m7_in, s10_aa_ff, s10_m7_ff, s10_p_ff;
   always_comb begin
      s10_a     = $signed(s9_p_ff) >>> 8;
      s10_aa_in = s10_a * s10_a;
      s10_m7_in = K_M7357 * s9_p_ff;
   end

   // stage 11: x1 * 3038
   logic [31:0] s11_m3_in, s11_x2_in, s11_m3_ff, s11_x2_ff, s11_p_ff;
   assign s11_m3_in = s10_aa_ff * K_3038;
   assign s11_x2_in = $signed(s10_m7_ff) >>> 16;

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_p_ff   <= s9_p_in;
         s9_sd_ff  <= s9_sd;
         s10_aa_ff <= s10_aa_in;
         s10_m7_ff <= s10_m7_in;
         s10_p_ff  <= s9_p_ff;
         s10_sd_ff <= s9_sd_ff;
         s11_m3_ff <= s11_m3_in;
         s11_x2_ff <= s11_x2_in;
         s11_p_ff  <= s10_p_ff;
         s11_sd_ff <= s10_sd_ff;
      end
   end

   // final sum, then output register and skid
   logic [31:0] fin_sum, fin_p;
   always_comb begin
      fin_sum = 32'($signed(s11_m3_ff) >>> 16) + s11_x2_ff + K_3791;
      fin_p   = s11_sd_ff.fault ? '0 : s11_p_ff + 32'($signed(fin_sum) >>> 4);
   end

   logic [31:0] out_p_ff, out_b5_ff, skid_p_ff, skid_b5_ff;
   logic        out_f_ff, skid_f_ff;
   logic        fin_v;
   assign fin_v = vld_ff[NS-1] && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_take) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (fin_v) begin
         if (!out_v_ff || rsp_ready) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_take) begin
            out_p_ff  <= skid_p_ff;
            out_b5_ff <= skid_b5_ff;
            out_f_ff  <= skid_f_ff;
         end
      end else if (fin_v) begin
         if (!out_v_ff || rsp_ready) begin
            out_p_ff  <= fin_p;
            out_b5_ff <= s11_sd_ff.b5;
            out_f_ff  <= s11_sd_ff.fault;
         end else begin
            skid_p_ff  <= fin_p;
            skid_b5_ff <= s11_sd_ff.b5;
            skid_f_ff  <= s11_sd_ff.fault;
         end
      end
   end

   assign rsp_valid            = out_v_ff;
   assign rsp_pressure_pa      = out_p_ff;
   assign rsp_temperature_term = out_b5_ff;
   assign rsp_divide_fault     = out_f_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a beat while output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !$past(skid_v_ff)) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid filled without a stalled output");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_fault) |-> (rsp_pressure_pa == 32'sd0))
      else $error("fault beat with nonzero pressure");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_ready) |=> out_v_ff)
      else $error("output beat lost under stall");

endmodule

### verif/baro_pressure_compensation_tb.sv
// Testbench for the barometric pressure compensation pipeline: directed and random beats,
// with a scoreboard class that predicts pressure, b5 and the divide fault flag.
// Depends on bpc_pkg and baro_pressure_compensation_top.
module testbench;
   import bpc_pkg::*;

   localparam logic [7:0] CSR_UNMAPPED = 8'hA5;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD = 300;

   typedef struct {
      logic [31:0] pressure;
      logic [31:0] b5;
      logic        fault;
   } comp_result_type;

   class comp_scoreboard_type;
      logic [63:0]     cal_ac1_ac4, cal_ac5_b2;
      logic [31:0]     cal_mc_md;
      logic [1:0]      oss;
      comp_result_type expected_q[$];
      int              errors;

      function new();
         cal_ac1_ac4 = '0;
         cal_ac5_b2  = '0;
         cal_mc_md   = '0;
         oss         = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [7:0] idx, logic [63:0] d);
         unique case (idx)
            CSR_CAL_AC1_TO_AC4: cal_ac1_ac4 = d;
            CSR_CAL_AC5_TO_B2:  cal_ac5_b2 = d;
            CSR_CAL_MC_MD:      cal_mc_md = d[31:0];
            CSR_OVERSAMPLING:   oss = d[1:0];
            default: ;
         endcase
      endfunction

      static function logic [31:0] sra(logic [31:0] v, int n);
         return $signed(v) >>> n;
      endfunction

      static function logic [31:0] sext(logic [15:0] w);
         return {{16{w[15]}}, w};
      endfunction

      // truncating signed divide, divisor nonzero
      static function logic [31:0] quot_trunc(logic [31:0] n, logic [31:0] d);
         logic [31:0] an, ad, q;
         an = n[31] ? -n : n;
         ad = d[31] ? -d : d;
         q  = an / ad;
         return (n[31] != d[31]) ? -q : q;
      endfunction

      function comp_result_type compensate(logic [15:0] raw_t, logic [18:0] raw_p);
         logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
         logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, den;
         comp_result_type r;
         ac1 = sext(cal_ac1_ac4[15:0]);
         ac2 = sext(cal_ac1_ac4[31:16]);
         ac3 = sext(cal_ac1_ac4[47:32]);
         ac4 = {16'd0, cal_ac1_ac4[63:48]};
         ac5 = {16'd0, cal_ac5_b2[15:0]};
         ac6 = {16'd0, cal_ac5_b2[31:16]};
         b1  = sext(cal_ac5_b2[47:32]);
         b2  = sext(cal_ac5_b2[63:48]);
         mc  = sext(cal_mc_md[15:0]);
         md  = sext(cal_mc_md[31:16]);
         ut  = {16'd0, raw_t};
         up  = {13'd0, raw_p};
         r.fault = 1'b0;
         x1  = sra((ut - ac6) * ac5, 15);
         den = x1 + md;
         if (den == 0) begin
            r.fault = 1'b1;
            x2 = 0;
         end else begin
            x2 = quot_trunc(mc << 11, den);
         end
         b5 = x1 + x2;
         b6 = b5 - 32'd4000;
         sq = sra(b6 * b6, 12);
         x1 = sra(b2 * sq, 11);
         x2 = sra(ac2 * b6, 11);
         x3 = x1 + x2;
         b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
         x1 = sra(ac3 * b6, 13);
         x2 = sra(b1 * sq, 16);
         x3 = sra(x1 + x2 + 32'd2, 2);
         b4 = (ac4 * (x3 + 32'd32768)) >> 15;
         b7 = (up - b3) * (32'd50000 >> oss);
         if (b4 == 0 || r.fault) begin
            r.fault = 1'b1;
            p = 0;
         end else begin
            p  = (b7 < 32'h8000_0000) ? (b7 << 1) / b4 : (b7 / b4) << 1;
            x1 = sra(p, 8) * sra(p, 8);
            x1 = sra(x1 * 32'd3038, 16);
            x2 = sra(32'hFFFF_E343 * p, 16);
            p  = p + sra(x1 + x2 + 32'd3791, 4);
         end
         r.pressure = p;
         r.b5       = b5;
         return r;
      endfunction

      function void note_reading(logic [15:0] raw_t, logic [18:0] raw_p);
         expected_q.push_back(compensate(raw_t, raw_p));
      endfunction

      function void check_result(logic [31:0] p, logic [31:0] b5, logic f);
         comp_result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result beat p=%0d b5=%0d", $signed(p), $signed(b5));
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (p !== e.pressure) begin
            $error("pressure_pa exp %0d got %0d", $signed(e.pressure), $signed(p));
            errors++;
         end
         if (b5 !== e.b5) begin
            $error("temperature_term exp %0d got %0d", $signed(e.b5), $signed(b5));
            errors++;
         end
         if (f !== e.fault) begin
            $error("divide_fault exp %0b got %0b", e.fault, f);
            errors++;
         end
      endfunction
   endclass

   logic               clock, reset;
   logic               req_valid, req_ready;
   logic [15:0]        req_raw_temperature;
   logic [18:0]        req_raw_pressure;
   logic               rsp_valid, rsp_ready;
   logic signed [31:0] rsp_pressure_pa, rsp_temperature_term;
   logic               rsp_divide_fault;
   logic               csr_valid, csr_ready;
   logic [7:0]         csr_index;
   logic [63:0]        csr_wdata;

   comp_scoreboard_type sb = new();
   bit   hold_off;
   int   idle_cycles;

   baro_pressure_compensation_top u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int g;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            g = pick_gap();
            if (g == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_pressure_pa, rsp_temperature_term, rsp_divide_fault);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_reading(logic [15:0] raw_t, logic [18:0] raw_p);
      int g;
      @(negedge clock);
      req_valid           <= 1'b1;
      req_raw_temperature <= raw_t;
      req_raw_pressure    <= raw_p;
      do @(posedge clock); while (!req_ready);
      sb.note_reading(raw_t, raw_p);
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [7:0] idx, logic [63:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_cal(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                           logic [1:0] mode);
      csr_write(CSR_CAL_AC1_TO_AC4, c0);
      csr_write(CSR_CAL_AC5_TO_B2, c1);
      csr_write(CSR_CAL_MC_MD, c2);
      csr_write(CSR_OVERSAMPLING, {62'd0, mode});
   endtask

   // typical part: ac1..ac4 = 408,-72,-14383,32741; ac5,ac6,b1,b2 = 32757,23153,6190,4
   localparam logic [63:0] TYP_C0 = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
   localparam logic [63:0] TYP_C1 = {16'd4, 16'd6190, 16'd23153, 16'd32757};
   localparam logic [63:0] TYP_C2 = {32'd0, 16'd2868, 16'hDDF9};

   function automatic logic [15:0] wiggle(logic [15:0] w);
      return w + 16'($urandom_range(0, 64)) - 16'd32;
   endfunction

   initial begin
      logic [63:0] c0, c1, c2;
      hold_off  = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure    = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset calibration: temperature divisor is zero
      send_reading(16'd0, 19'd0);
      send_reading(16'hFFFF, 19'h7FFFF);
      wait_idle();

      for (int m = 0; m < 4; m++) begin
         load_cal(TYP_C0, TYP_C1, TYP_C2, 2'(m));
         send_reading(16'd27898, 19'd23843 << m);
         send_reading(16'd0, 19'h7FFFF);
         send_reading(16'hFFFF, 19'd0);
         send_reading(16'h5555, 19'h2AAAA);
         wait_idle();
      end

      // pressure divisor zero: ac4 = 0
      load_cal({16'd0, TYP_C0[47:0]}, TYP_C1, TYP_C2, 2'd0);
      send_reading(16'd27898, 19'd23843);
      send_reading(16'hAAAA, 19'h55555);
      wait_idle();

      // all-ones calibration, then a write to an unmapped index that must be ignored
      load_cal('1, '1, '1, 2'd3);
      csr_write(CSR_UNMAPPED, 64'h0123_4567_89AB_CDEF);
      send_reading(16'd0, 19'd0);
      send_reading(16'hFFFF, 19'h7FFFF);
      send_reading(16'd1234, 19'd4321);
      wait_idle();

      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 3 == 2) begin
            c0 = {$urandom, $urandom};
            c1 = {$urandom, $urandom};
            c2 = {$urandom, $urandom};
         end else begin
            c0 = {wiggle(TYP_C0[63:48]), wiggle(TYP_C0[47:32]),
                  wiggle(TYP_C0[31:16]), wiggle(TYP_C0[15:0])};
            c1 = {wiggle(TYP_C1[63:48]), wiggle(TYP_C1[47:32]),
                  wiggle(TYP_C1[31:16]), wiggle(TYP_C1[15:0])};
            c2 = {32'd0, wiggle(TYP_C2[31:16]), wiggle(TYP_C2[15:0])};
         end
         load_cal(c0, c1, c2, 2'($urandom_range(0, 3)));
         for (int i = 0; i < 90; i++) begin
            if (ph == 1 && i == 10) hold_off = 1'b1;
            if ($urandom_range(0, 1))
               send_reading(16'($urandom_range(20000, 36000)),
                            19'($urandom_range(15000, 100000)));
            else
               send_reading(16'($urandom), 19'($urandom));
         end
         wait_idle();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
